FILE: rtl/gdad_pkg.sv
`timescale 1ns / 1ps
package gdad_pkg;

   localparam int ADD_WIDTH = 16;
   // day-of-year plus the count fits below 2**(ADD_WIDTH+1) + 366
   localparam int REM_W     = ADD_WIDTH + 2;
   localparam int DAY_W     = 5;
   localparam int MON_W     = 4;
   localparam int YEAR_W    = 14;
   localparam int STEP_W    = 3;
   localparam int QUOT_W    = 8;   // year / 100 stays below 164
   localparam int CENT_W    = 7;   // year mod 100
   localparam int RECIP_W   = 13;

   // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
   localparam logic [RECIP_W-1:0] RECIP_100   = RECIP_W'(5243);
   localparam int                 RECIP_SHIFT = 19;

   localparam logic [YEAR_W-1:0] YEAR_MAX    = {YEAR_W{1'b1}};
   localparam logic [MON_W-1:0]  MON_JAN     = MON_W'(1);
   localparam logic [MON_W-1:0]  MON_FEB     = MON_W'(2);
   localparam logic [MON_W-1:0]  MON_DEC     = MON_W'(12);
   localparam logic [CENT_W-1:0] CENT_LAST   = CENT_W'(99);
   localparam logic [CENT_W-1:0] CENT_HUNDRED = CENT_W'(100);

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_REQ_VALID,
      COND_MON_NE_START,
      COND_REM_GT_LEN,
      COND_OUT_FREE
   } cond_type;

   typedef enum logic [2:0] {
      REM_HOLD,
      REM_LOAD_DAY,
      REM_ADD_LEN,
      REM_ADD_CNT,
      REM_SUB_LEN
   } rem_op_type;

   typedef enum logic [1:0] {
      MON_HOLD,
      MON_ONE,
      MON_INC,
      MON_ADVANCE
   } mon_op_type;

   // one word of the control store
   typedef struct packed {
      cond_type   cond;
      logic       load;
      logic       mod;
      rem_op_type rem_op;
      mon_op_type mon_op;
      logic       emit;
      step_type   next_t;
      step_type   next_f;
   } uword_type;

   // datapath commands, already gated by the branch condition
   typedef struct packed {
      logic       load;
      logic       mod;
      rem_op_type rem_op;
      mon_op_type mon_op;
      logic       emit;
   } ctrl_type;

   typedef struct packed {
      logic mon_ne_start;
      logic rem_gt_len;
   } status_type;

   localparam step_type ST_IDLE = STEP_W'(0);
   localparam step_type ST_MOD  = STEP_W'(1);
   localparam step_type ST_DOY  = STEP_W'(2);
   localparam step_type ST_ADD  = STEP_W'(3);
   localparam step_type ST_WALK = STEP_W'(4);
   localparam step_type ST_EMIT = STEP_W'(5);

   function automatic uword_type ucode(input step_type step);
      uword_type w;
      w = '{cond: COND_ALWAYS, load: 1'b0, mod: 1'b0, rem_op: REM_HOLD,
            mon_op: MON_HOLD, emit: 1'b0, next_t: ST_IDLE, next_f: ST_IDLE};
      unique case (step)
         ST_IDLE: begin
            w.cond   = COND_REQ_VALID;
            w.load   = 1'b1;
            w.rem_op = REM_LOAD_DAY;
            w.next_t = ST_MOD;
            w.next_f = ST_IDLE;
         end
         ST_MOD: begin
            w.mod    = 1'b1;
            w.mon_op = MON_ONE;
            w.next_t = ST_DOY;
            w.next_f = ST_DOY;
         end
         ST_DOY: begin
            w.cond   = COND_MON_NE_START;
            w.rem_op = REM_ADD_LEN;
            w.mon_op = MON_INC;
            w.next_t = ST_DOY;
            w.next_f = ST_ADD;
         end
         ST_ADD: begin
            w.rem_op = REM_ADD_CNT;
            w.mon_op = MON_ONE;
            w.next_t = ST_WALK;
            w.next_f = ST_WALK;
         end
         ST_WALK: begin
            w.cond   = COND_REM_GT_LEN;
            w.rem_op = REM_SUB_LEN;
            w.mon_op = MON_ADVANCE;
            w.next_t = ST_WALK;
            w.next_f = ST_EMIT;
         end
         ST_EMIT: begin
            w.cond   = COND_OUT_FREE;
            w.emit   = 1'b1;
            w.next_t = ST_IDLE;
            w.next_f = ST_EMIT;
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (mon)
         MON_W'(4), MON_W'(6), MON_W'(9), MON_W'(11): len = DAY_W'(30);
         MON_FEB:                                     len = leap ? DAY_W'(29) : DAY_W'(28);
         default:                                     len = DAY_W'(31);
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/gdad_datapath.sv
`timescale 1ns / 1ps
module gdad_datapath (
   input  logic                          clock,
   input  logic [gdad_pkg::DAY_W-1:0]     req_start_day,
   input  logic [gdad_pkg::MON_W-1:0]     req_start_month,
   input  logic [gdad_pkg::YEAR_W-1:0]    req_start_year,
   input  logic [gdad_pkg::ADD_WIDTH-1:0] req_days_to_add,
   input  gdad_pkg::ctrl_type             ctrl,
   output gdad_pkg::status_type           status,
   output logic [gdad_pkg::DAY_W-1:0]     rsp_end_day,
   output logic [gdad_pkg::MON_W-1:0]     rsp_end_month,
   output logic [gdad_pkg::YEAR_W-1:0]    rsp_end_year
);
   import gdad_pkg::*;

   localparam int PROD_W = YEAR_W + RECIP_W;

   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [MON_W-1:0]     mon_ff, mon_in;
   logic [MON_W-1:0]     smon_ff, smon_in;
   logic [YEAR_W-1:0]    yr_ff, yr_in;
   logic [ADD_WIDTH-1:0] add_ff, add_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic [CENT_W-1:0]    cent_ff, cent_in;
   logic [1:0]           cnum_ff, cnum_in;
   logic [DAY_W-1:0]     day_o_ff, day_o_in;
   logic [MON_W-1:0]     mon_o_ff, mon_o_in;
   logic [YEAR_W-1:0]    yr_o_ff, yr_o_in;

   logic [PROD_W-1:0]    prod;
   logic [YEAR_W-1:0]    quot_x100;
   logic                 leap;
   logic [DAY_W-1:0]     len;
   logic [DAY_W-1:0]     day_clamp;
   logic [MON_W-1:0]     mon_clamp;

   always_comb begin
      // leap: divisible by 4 but not 100, or by 400
      leap = ((yr_ff[1:0] == 2'd0) && (cent_ff != '0)) ||
             ((cent_ff == '0) && (cnum_ff == 2'd0));
      len  = month_len(mon_ff, leap);
      status.mon_ne_start = (mon_ff != smon_ff);
      status.rem_gt_len   = (rem_ff > REM_W'(len));

      day_clamp = (req_start_day == '0) ? DAY_W'(1) : req_start_day;
      if (req_start_month == '0) begin
         mon_clamp = MON_JAN;
      end else if (req_start_month > MON_DEC) begin
         mon_clamp = MON_DEC;
      end else begin
         mon_clamp = req_start_month;
      end

      prod      = PROD_W'(req_start_year) * PROD_W'(RECIP_100);
      quot_x100 = YEAR_W'(quot_ff) * YEAR_W'(CENT_HUNDRED);

      rem_in   = rem_ff;
      mon_in   = mon_ff;
      smon_in  = smon_ff;
      yr_in    = yr_ff;
      add_in   = add_ff;
      quot_in  = quot_ff;
      cent_in  = cent_ff;
      cnum_in  = cnum_ff;
      day_o_in = day_o_ff;
      mon_o_in = mon_o_ff;
      yr_o_in  = yr_o_ff;

      if (ctrl.load) begin
         smon_in = mon_clamp;
         yr_in   = req_start_year;
         add_in  = req_days_to_add;
         quot_in = prod[RECIP_SHIFT +: QUOT_W];
      end

      // split the year into year mod 100 and century mod 4
      if (ctrl.mod) begin
         cent_in = CENT_W'(yr_ff - quot_x100);
         cnum_in = quot_ff[1:0];
      end

      case (ctrl.rem_op)
         REM_LOAD_DAY: rem_in = REM_W'(day_clamp);
         REM_ADD_LEN:  rem_in = rem_ff + REM_W'(len);
         REM_ADD_CNT:  rem_in = rem_ff + REM_W'(add_ff);
         REM_SUB_LEN:  rem_in = rem_ff - REM_W'(len);
         default:      rem_in = rem_ff;
      endcase

      case (ctrl.mon_op)
         MON_ONE: mon_in = MON_JAN;
         MON_INC: mon_in = mon_ff + MON_W'(1);
         MON_ADVANCE: begin
            if (mon_ff == MON_DEC) begin
               mon_in = MON_JAN;
               if (yr_ff == YEAR_MAX) begin
                  // year wraps to zero, which is a leap year
                  yr_in   = '0;
                  cent_in = '0;
                  cnum_in = 2'd0;
               end else begin
                  yr_in = yr_ff + YEAR_W'(1);
                  if (cent_ff == CENT_LAST) begin
                     cent_in = '0;
                     cnum_in = cnum_ff + 2'd1;
                  end else begin
                     cent_in = cent_ff + CENT_W'(1);
                  end
               end
            end else begin
               mon_in = mon_ff + MON_W'(1);
            end
         end
         default: mon_in = mon_ff;
      endcase

      if (ctrl.emit) begin
         day_o_in = rem_ff[DAY_W-1:0];
         mon_o_in = mon_ff;
         yr_o_in  = yr_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      mon_ff   <= mon_in;
      smon_ff  <= smon_in;
      yr_ff    <= yr_in;
      add_ff   <= add_in;
      quot_ff  <= quot_in;
      cent_ff  <= cent_in;
      cnum_ff  <= cnum_in;
      day_o_ff <= day_o_in;
      mon_o_ff <= mon_o_in;
      yr_o_ff  <= yr_o_in;
   end

   assign rsp_end_day   = day_o_ff;
   assign rsp_end_month = mon_o_ff;
   assign rsp_end_year  = yr_o_ff;

endmodule

FILE: rtl/gregorian_date_add_days_top.sv
`timescale 1ns / 1ps
// Channel  Handshake                Payload
// req      req_valid / req_ready    start_day, start_month, start_year, days_to_add
// rsp      rsp_valid / rsp_ready    end_day, end_month, end_year
//
// The time a request takes grows with its start month and with the number of
// months the walk crosses (about (day of year + count) / 30.4, up to roughly
// 2160 for the largest count). The month walk loop of the microcode covers
// one month per cycle.
// Reset clears the step counter and the result valid; no clearing pass.
// A result waiting on rsp_ready does not block the next request; the
// sequencer only stalls at its last step if the previous result is still held.
module gregorian_date_add_days_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gdad_pkg::DAY_W-1:0]     req_start_day,
   input  logic [gdad_pkg::MON_W-1:0]     req_start_month,
   input  logic [gdad_pkg::YEAR_W-1:0]    req_start_year,
   input  logic [gdad_pkg::ADD_WIDTH-1:0] req_days_to_add,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gdad_pkg::DAY_W-1:0]     rsp_end_day,
   output logic [gdad_pkg::MON_W-1:0]     rsp_end_month,
   output logic [gdad_pkg::YEAR_W-1:0]    rsp_end_year
);
   import gdad_pkg::*;

   step_type   step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   uword_type  uword;
   logic       cond_true;
   ctrl_type   ctrl;
   status_type status;

   always_comb begin
      // fetch the control word for the current step
      uword = ucode(step_ff);

      unique case (uword.cond)
         COND_ALWAYS:       cond_true = 1'b1;
         COND_REQ_VALID:    cond_true = req_valid;
         COND_MON_NE_START: cond_true = status.mon_ne_start;
         COND_REM_GT_LEN:   cond_true = status.rem_gt_len;
         COND_OUT_FREE:     cond_true = !rsp_valid_ff || rsp_ready;
         default:           cond_true = 1'b0;
      endcase

      // drop the datapath commands when the branch is not taken
      ctrl.load   = uword.load & cond_true;
      ctrl.mod    = uword.mod & cond_true;
      ctrl.rem_op = cond_true ? uword.rem_op : REM_HOLD;
      ctrl.mon_op = cond_true ? uword.mon_op : MON_HOLD;
      ctrl.emit   = uword.emit & cond_true;

      step_in = cond_true ? uword.next_t : uword.next_f;

      // hold the result until taken; a fresh result replaces a taken one
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // the idle step is the only one that takes a request
   assign req_ready = (step_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   gdad_datapath u_datapath (
      .clock           (clock),
      .req_start_day   (req_start_day),
      .req_start_month (req_start_month),
      .req_start_year  (req_start_year),
      .req_days_to_add (req_days_to_add),
      .ctrl            (ctrl),
      .status          (status),
      .rsp_end_day     (rsp_end_day),
      .rsp_end_month   (rsp_end_month),
      .rsp_end_year    (rsp_end_year)
   );

endmodule
